FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge out of reset
`define RUM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define RUM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/rum_pkg.sv
// ----------------------------------------------------------------------------
// rum_pkg
// field widths, command codes and scan unit control types for the mapper
// ----------------------------------------------------------------------------
package rum_pkg;

  localparam int CmdW      = 2;
  localparam int RegFW     = 5;
  localparam int DuFW      = 5;
  localparam int SlotFW    = 3;
  localparam int MapFW     = 6;
  localparam int PhysFW    = 4;
  localparam int CountW    = 8;
  localparam int InTdataW  = 8;
  localparam int InTuserW  = 2;
  localparam int OutTdataW = 24;

  localparam logic [CmdW-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CmdW-1:0] CMD_USE    = 2'd1;
  localparam logic [CmdW-1:0] CMD_MAP    = 2'd2;
  localparam logic [CmdW-1:0] CMD_LOOKUP = 2'd3;

  localparam logic [CountW-1:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic             clr;
    logic             en;
    logic [MapFW-1:0] idx;
  } rum_scan_ctrl_t;

  typedef struct packed {
    logic             found;
    logic [MapFW-1:0] pick;
  } rum_scan_stat_t;

endpackage

FILE: rtl/rum_ram.sv
// ----------------------------------------------------------------------------
// rum_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module rum_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rum_max_unit.sv
// ----------------------------------------------------------------------------
// rum_max_unit
// running maximum over a stream of counter words, earliest word wins ties
// ----------------------------------------------------------------------------
module rum_max_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rum_pkg::rum_scan_ctrl_t      ctrl_i,
  input  logic [rum_pkg::CountW-1:0]   data_i,
  output rum_pkg::rum_scan_stat_t      stat_o
);

  logic [rum_pkg::CountW-1:0] best_q, best_d;
  logic [rum_pkg::MapFW-1:0]  pick_q, pick_d;

  always_comb begin
    best_d = best_q;
    pick_d = pick_q;
    if (ctrl_i.clr) begin
      best_d = '0;
      pick_d = '0;
    end else if (ctrl_i.en && (data_i > best_q)) begin
      best_d = data_i;
      pick_d = ctrl_i.idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
      pick_q <= '0;
    end else begin
      best_q <= best_d;
      pick_q <= pick_d;
    end
  end

  assign stat_o.found = (best_q != '0);
  assign stat_o.pick  = pick_q;

endmodule

FILE: rtl/register_usage_top_k_mapper.sv
// ----------------------------------------------------------------------------
// register_usage_top_k_mapper
// use counters per guest register and a top-k slot map built from them
// ----------------------------------------------------------------------------
// Use counters live in a RAM with one read port; a valid bit per counter
// makes reset and the clear command take effect at once, so there is no
// clearing pass. Clear and lookup words go from accept straight to the
// emit step; a use word first passes the use state, which reads its counter.
// A map word runs NUM_SLOTS rounds (one counter read per cycle into a single
// compare unit, then pick and emit); the emit step waits out a stalled output.
// One word is in work at a time; the result register lets the next word in
// while the last result still waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module register_usage_top_k_mapper #(
  parameter int NUM_SLOTS      = 7,
  parameter int NUM_GUEST_REGS = 32,
  parameter int FIRST_HOST_REG = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // reg_index[4:0], zero pad
  input  logic [rum_pkg::InTdataW-1:0]    s_axis_tdata_i,
  // cmd[1:0]
  input  logic [rum_pkg::InTuserW-1:0]    s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // distinct_used[4:0], over_limit[5], slot[8:6], mapped_reg[14:9],
  // phys_reg[18:15], zero pad
  output logic [rum_pkg::OutTdataW-1:0]   m_axis_tdata_o,
  output logic                            m_axis_tlast_o
);

  localparam int IdxW   = (NUM_GUEST_REGS > 1) ? $clog2(NUM_GUEST_REGS) : 1;
  localparam int SlotW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int DistW  = IdxW;
  localparam int CntW   = rum_pkg::CountW;
  localparam int DuW    = rum_pkg::DuFW;
  localparam int SlW    = rum_pkg::SlotFW;
  localparam int MapW   = rum_pkg::MapFW;
  localparam int PhysW  = rum_pkg::PhysFW;
  localparam int RegW   = rum_pkg::RegFW;
  localparam logic [MapW-1:0] NoneCode = MapW'(NUM_GUEST_REGS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_USE   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_PICK  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]                state_q, state_d;
  logic [2:0]                nxt_q, nxt_d;
  logic [RegW-1:0]           reg_q, reg_d;
  logic [SlotW-1:0]          slot_q, slot_d;
  logic [IdxW-1:0]           scan_idx_q, scan_idx_d;
  logic [IdxW-1:0]           rd_idx_q;
  logic                      rd_en_q, rd_vld_q, rd_vld_d;
  logic [NUM_GUEST_REGS-1:0] cnt_vld_q, cnt_vld_d;
  logic [DistW-1:0]          distinct_q, distinct_d;
  logic [MapW-1:0]           slot_map_q [NUM_SLOTS];
  logic [MapW-1:0]           slot_map_d [NUM_SLOTS];

  logic [DuW-1:0]   res_du_q, res_du_d;
  logic             res_ov_q, res_ov_d;
  logic [SlW-1:0]   res_slot_q, res_slot_d;
  logic [MapW-1:0]  res_map_q, res_map_d;
  logic [PhysW-1:0] res_phys_q, res_phys_d;
  logic             res_last_q, res_last_d;

  logic             out_vld_q, out_vld_d;
  logic [DuW-1:0]   out_du_q, out_du_d;
  logic             out_ov_q, out_ov_d;
  logic [SlW-1:0]   out_slot_q, out_slot_d;
  logic [MapW-1:0]  out_map_q, out_map_d;
  logic [PhysW-1:0] out_phys_q, out_phys_d;
  logic             out_last_q, out_last_d;

  logic                   in_acc;
  logic [rum_pkg::CmdW-1:0] in_cmd;
  logic [RegW-1:0]        in_reg;
  logic                   in_rng;
  logic                   use_rng;
  logic [IdxW-1:0]        use_idx;
  logic [IdxW-1:0]        pick_idx;
  logic [IdxW-1:0]        ram_raddr;
  logic                   ram_we;
  logic [CntW-1:0]        ram_wdata;
  logic [CntW-1:0]        ram_rdata;
  logic [CntW-1:0]        cnt_rd;
  logic [PhysW-1:0]       phys_lk;
  logic                   out_free;
  logic                   last_round;

  rum_pkg::rum_scan_ctrl_t scan_ctrl;
  rum_pkg::rum_scan_stat_t scan_stat;

  assign in_cmd   = s_axis_tuser_i[rum_pkg::CmdW-1:0];
  assign in_reg   = s_axis_tdata_i[RegW-1:0];
  assign in_rng   = (32'(in_reg) < NUM_GUEST_REGS);
  assign in_acc   = s_axis_tvalid_i && (state_q == S_IDLE);
  assign use_rng  = (32'(reg_q) < NUM_GUEST_REGS);
  assign use_idx  = IdxW'(32'(reg_q));
  assign pick_idx = IdxW'(32'(scan_stat.pick));
  assign cnt_rd   = rd_vld_q ? ram_rdata : '0;
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign last_round = (slot_q == SlotW'(NUM_SLOTS - 1));
  assign ram_raddr  = (state_q == S_IDLE) ? IdxW'(32'(in_reg)) : scan_idx_q;
  assign rd_vld_d   = (32'(ram_raddr) < NUM_GUEST_REGS) ? cnt_vld_q[ram_raddr] : 1'b0;
  assign ram_we     = (state_q == S_USE) && use_rng && (cnt_rd != rum_pkg::COUNT_MAX);
  assign ram_wdata  = cnt_rd + CntW'(1);

  assign scan_ctrl.clr = (in_acc && (in_cmd == rum_pkg::CMD_MAP)) || (state_q == S_PICK);
  assign scan_ctrl.en  = rd_en_q;
  assign scan_ctrl.idx = MapW'(32'(rd_idx_q));

  rum_ram #(
    .Width(CntW),
    .Depth(NUM_GUEST_REGS)
  ) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(use_idx),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  rum_max_unit u_max (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(scan_ctrl),
    .data_i(cnt_rd),
    .stat_o(scan_stat)
  );

  always_comb begin
    logic hit;
    hit     = 1'b0;
    phys_lk = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (in_rng && !hit && (slot_map_q[i] == MapW'(32'(in_reg)))) begin
        hit     = 1'b1;
        phys_lk = PhysW'(i + FIRST_HOST_REG);
      end
    end
  end

  always_comb begin
    logic [DistW-1:0] dist_new;
    dist_new   = distinct_q;
    state_d    = state_q;
    nxt_d      = nxt_q;
    reg_d      = reg_q;
    slot_d     = slot_q;
    scan_idx_d = scan_idx_q;
    cnt_vld_d  = cnt_vld_q;
    distinct_d = distinct_q;
    slot_map_d = slot_map_q;
    res_du_d   = res_du_q;
    res_ov_d   = res_ov_q;
    res_slot_d = res_slot_q;
    res_map_d  = res_map_q;
    res_phys_d = res_phys_q;
    res_last_d = res_last_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_du_d   = out_du_q;
    out_ov_d   = out_ov_q;
    out_slot_d = out_slot_q;
    out_map_d  = out_map_q;
    out_phys_d = out_phys_q;
    out_last_d = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          reg_d      = in_reg;
          nxt_d      = S_IDLE;
          res_du_d   = '0;
          res_ov_d   = 1'b0;
          res_slot_d = '0;
          res_map_d  = '0;
          res_phys_d = '0;
          res_last_d = 1'b1;
          case (in_cmd)
            rum_pkg::CMD_CLEAR: begin
              cnt_vld_d  = '0;
              distinct_d = '0;
              state_d    = S_EMIT;
            end
            rum_pkg::CMD_USE: begin
              state_d = S_USE;
            end
            rum_pkg::CMD_MAP: begin
              slot_d     = '0;
              scan_idx_d = IdxW'(1);
              state_d    = S_SCAN;
            end
            rum_pkg::CMD_LOOKUP: begin
              res_phys_d = phys_lk;
              state_d    = S_EMIT;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_USE: begin
        if (ram_we) begin
          cnt_vld_d[use_idx] = 1'b1;
        end
        if (use_rng && (cnt_rd == '0) && (reg_q != '0)) begin
          dist_new = distinct_q + DistW'(1);
        end
        distinct_d = dist_new;
        res_du_d   = DuW'(32'(dist_new));
        res_ov_d   = (32'(dist_new) > NUM_SLOTS);
        state_d    = S_EMIT;
      end
      S_SCAN: begin
        scan_idx_d = scan_idx_q + IdxW'(1);
        if (scan_idx_q == IdxW'(NUM_GUEST_REGS - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_PICK;
      end
      S_PICK: begin
        if (scan_stat.found) begin
          cnt_vld_d[pick_idx]  = 1'b0;
          distinct_d           = distinct_q - DistW'(1);
          slot_map_d[slot_q]   = scan_stat.pick;
          res_map_d            = scan_stat.pick;
        end else begin
          slot_map_d[slot_q]   = NoneCode;
          res_map_d            = NoneCode;
        end
        res_du_d   = '0;
        res_ov_d   = 1'b0;
        res_phys_d = '0;
        res_slot_d = SlW'(32'(slot_q));
        res_last_d = last_round;
        nxt_d      = last_round ? S_IDLE : S_SCAN;
        slot_d     = slot_q + SlotW'(1);
        scan_idx_d = IdxW'(1);
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_du_d   = res_du_q;
          out_ov_d   = res_ov_q;
          out_slot_d = res_slot_q;
          out_map_d  = res_map_q;
          out_phys_d = res_phys_q;
          out_last_d = res_last_q;
          state_d    = nxt_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      nxt_q      <= S_IDLE;
      slot_q     <= '0;
      scan_idx_q <= '0;
      rd_en_q    <= 1'b0;
      rd_vld_q   <= 1'b0;
      cnt_vld_q  <= '0;
      distinct_q <= '0;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_map_q[i] <= NoneCode;
      end
    end else begin
      state_q    <= state_d;
      nxt_q      <= nxt_d;
      slot_q     <= slot_d;
      scan_idx_q <= scan_idx_d;
      rd_en_q    <= (state_q == S_SCAN);
      rd_vld_q   <= rd_vld_d;
      cnt_vld_q  <= cnt_vld_d;
      distinct_q <= distinct_d;
      out_vld_q  <= out_vld_d;
      slot_map_q <= slot_map_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reg_q      <= reg_d;
    rd_idx_q   <= scan_idx_q;
    res_du_q   <= res_du_d;
    res_ov_q   <= res_ov_d;
    res_slot_q <= res_slot_d;
    res_map_q  <= res_map_d;
    res_phys_q <= res_phys_d;
    res_last_q <= res_last_d;
    out_du_q   <= out_du_d;
    out_ov_q   <= out_ov_d;
    out_slot_q <= out_slot_d;
    out_map_q  <= out_map_d;
    out_phys_q <= out_phys_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {5'b0, out_phys_q, out_map_q, out_slot_q, out_ov_q, out_du_q};

  `RUM_ASSERT(a_distinct_range, 32'(distinct_q) < NUM_GUEST_REGS, "distinct count out of range")
  `RUM_ASSERT_NEXT(a_map_start, in_acc && (in_cmd == rum_pkg::CMD_MAP), state_q == S_SCAN, "map word did not start a scan")
  `RUM_ASSERT(a_pick_live, (state_q == S_PICK && scan_stat.found) |-> cnt_vld_q[pick_idx], "picked counter not live")
  `RUM_ASSERT(a_out_from_emit, $rose(out_vld_q) |-> $past(state_q == S_EMIT), "result loaded outside emit")

endmodule
